[design/ldf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line package
// Shared widths, sizes and the command type that travels from the front end
// through the queue to the ring engine.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int RING_DEPTH   = 65536;
  localparam int MAX_BLOCK    = 8192;
  localparam int FADE_SAMPLES = 128;
  localparam int FIFO_DEPTH   = 4;

  localparam int ADDR_W  = $clog2(RING_DEPTH);
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W = 16;
  localparam int LEN_W   = 14;
  localparam int POS_W   = $clog2(MAX_BLOCK) + 1;
  localparam int FADE_W  = $clog2(FADE_SAMPLES) + 1;
  localparam int KEEP_W  = $clog2(FADE_SAMPLES);

  localparam int DELAY_LIMIT = RING_DEPTH - MAX_BLOCK - 1;

  // Gains are Q1.16 values in the range 0 to 1.0 inclusive.
  localparam int GAIN_SHIFT = 16;
  localparam int GAIN_W     = GAIN_SHIFT + 1;
  localparam int UNITY      = 1 << GAIN_SHIFT;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
    logic [POS_W-1:0]           len;
    logic                       flush;
    logic [ADDR_W-1:0]          delay;
  } cmd_t;

endpackage

[design/ldf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line channel interfaces
// Valid/ready channels for input requests and for delayed samples.
// ----------------------------------------------------------------------------
interface ldf_in_if import ldf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       block_start;
  logic [LEN_W-1:0]           block_length;
  logic                       flush_request;

  modport source (output valid, sample_in, block_start, block_length, flush_request,
                  input ready);
  modport sink (input valid, sample_in, block_start, block_length, flush_request,
                output ready);
endinterface

interface ldf_out_if import ldf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] delayed_sample;

  modport source (output valid, delayed_sample, input ready);
  modport sink (input valid, delayed_sample, output ready);
endinterface

[design/ldf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider, one quotient bit per cycle, giving round(num/den) in Q1.16.
// ----------------------------------------------------------------------------
module ldf_div import ldf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FADE_W-1:0] num_i,
  input  logic [FADE_W-1:0] den_i,
  output logic              done_o,
  output logic [GAIN_W-1:0] quot_o
);

  localparam int DIVW = FADE_W + GAIN_SHIFT + 1;
  localparam int CW   = $clog2(DIVW + 1);

  logic [FADE_W:0]   rem_q;
  logic [DIVW-1:0]   dvd_q;
  logic [FADE_W-1:0] den_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [FADE_W:0]   trial;

  assign trial = {rem_q[FADE_W-1:0], dvd_q[DIVW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvd_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        dvd_q  <= {1'b0, num_i, GAIN_SHIFT'(0)} + DIVW'(den_i >> 1);
        den_q  <= den_i;
        cnt_q  <= CW'(DIVW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= trial - {1'b0, den_q};
          dvd_q <= {dvd_q[DIVW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          dvd_q <= {dvd_q[DIVW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? GAIN_W'(UNITY) : dvd_q[GAIN_W-1:0];

endmodule

[design/ldf_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short queue between the front end and the ring engine.
// ----------------------------------------------------------------------------
module ldf_fifo import ldf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          slot_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q;
  logic [PW-1:0] rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push;
  logic          do_pop;

  assign ready_o = (cnt_q != CW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[design/ldf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Holds the target delay register, accepts requests and turns them into
// commands with saturated block length and delay.
// ----------------------------------------------------------------------------
module ldf_front import ldf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ldf_in_if.sink             in_i,
  input  logic               cfg_we_i,
  input  logic [DELAY_W-1:0] cfg_wdata_i,
  input  logic               clearing_i,
  input  logic               fifo_ready_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [DELAY_W-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = fifo_ready_i && !clearing_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    cmd_o.sample = in_i.sample_in;
    cmd_o.start  = in_i.block_start;
    cmd_o.flush  = in_i.flush_request;
    cmd_o.len    = (32'(in_i.block_length) > MAX_BLOCK) ? POS_W'(MAX_BLOCK)
                                                        : POS_W'(in_i.block_length);
    cmd_o.delay  = (32'(target_q) > DELAY_LIMIT) ? ADDR_W'(DELAY_LIMIT)
                                                 : ADDR_W'(target_q);
  end

endmodule

[design/ldf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring engine
// Sequencer that owns the ring memory: reset clear, block-start passes,
// per-sample fades and the delay write and read.
// ----------------------------------------------------------------------------
module ldf_back import ldf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      clearing_o,
  ldf_out_if.source out_o
);

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_BEGIN, ST_PRE, ST_FO_RD, ST_FO_DATA, ST_FO_WR, ST_GAP,
    ST_CAP_RD, ST_CAP_DATA, ST_APPLY, ST_FL, ST_FL_DATA, ST_FL_WR,
    ST_ITEM, ST_PW, ST_PW_FL, ST_PW_WR, ST_FI_CHK, ST_FI_DONE,
    ST_XF_DIV, ST_XF_WAIT, ST_XF_P1, ST_XF_P2, ST_XF_SUM,
    ST_RING_WR, ST_RING_RD, ST_RING_DATA, ST_OUT,
    ST_M_DIV, ST_M_WAIT, ST_M_PROD, ST_M_RND
  } state_e;

  typedef enum logic [1:0] {
    MODE_NONE, MODE_INC, MODE_DEC
  } fade_e;

  localparam logic [ADDR_W-1:0] FADE_A = ADDR_W'(FADE_SAMPLES);

  function automatic logic signed [SAMPLE_W-1:0] rnd16(input logic signed [PROD_W-1:0] t);
    logic signed [PROD_W-1:0] u;
    u = t + PROD_W'(1 << (GAIN_SHIFT - 1));
    return SAMPLE_W'(u >>> GAIN_SHIFT);
  endfunction

  logic signed [SAMPLE_W-1:0] ring_q [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] keep_q [FADE_SAMPLES];
  logic signed [SAMPLE_W-1:0] mem_rd_q;
  logic signed [SAMPLE_W-1:0] keep_rd_q;

  state_e state_q, ret_q;
  fade_e  fmode_q;
  cmd_t   cmd_q;

  logic [ADDR_W-1:0] cnt_q, lim_q, gap_q;
  logic [ADDR_W-1:0] rd_q, wr_q, applied_q, pre_base_q;
  logic [POS_W-1:0]  pos_q, blen_q;
  logic [FADE_W-1:0] flen_q, pre_cnt_q, pre_fade_q, pre_old_q, flush_len_q;
  logic [FADE_W-1:0] gnum_q, gden_q;
  logic              ginv_q, flush_on_q;
  logic [GAIN_W-1:0] g_q;
  logic signed [SAMPLE_W-1:0] x_q, v_q, y_q;
  logic signed [PROD_W-1:0]   prod_q, prod2_q;
  logic              out_valid_q;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_addr;
  logic signed [SAMPLE_W-1:0] mem_wd;
  logic                       div_start, div_done;
  logic [GAIN_W-1:0]          div_quot;

  // Block-start decisions.
  logic [ADDR_W-1:0] p, d, add_n, lout_n, xn, nlen, pre_s;
  logic              d_small;
  logic [FADE_W:0]   sf;

  ldf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (gnum_q),
    .den_i   (gden_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign div_start  = (state_q == ST_M_DIV) || (state_q == ST_XF_DIV);
  assign clearing_o = (state_q == ST_CLEAR);
  assign cmd_pop_o  = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.delayed_sample = y_q;

  always_comb begin
    p       = cmd_q.delay;
    d       = applied_q;
    nlen    = ADDR_W'(cmd_q.len);
    d_small = d < FADE_A;
    add_n   = '0;
    lout_n  = FADE_A;
    if (d_small) begin
      add_n  = ((FADE_A - d) < (p - d)) ? (FADE_A - d) : (p - d);
      lout_n = d + add_n;
    end
    xn = (d < FADE_A) ? d : FADE_A;
    if (nlen < xn) begin
      xn = nlen;
    end
    pre_s = ADDR_W'(pre_cnt_q) - ADDR_W'(pos_q);
    sf    = (FADE_W + 1)'(pre_old_q) + (FADE_W + 1)'(pos_q);
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = rd_q;
    mem_wd   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q;
      end
      ST_PRE: begin
        mem_we   = cnt_q < lim_q;
        mem_addr = pre_base_q + cnt_q;
      end
      ST_FO_RD:  mem_addr = wr_q - cnt_q;
      ST_FO_WR: begin
        mem_we   = 1'b1;
        mem_addr = wr_q - cnt_q;
        mem_wd   = v_q;
      end
      ST_GAP: begin
        mem_we   = cnt_q < lim_q;
        mem_addr = wr_q + cnt_q;
      end
      ST_CAP_RD: mem_addr = rd_q + cnt_q;
      ST_FL: begin
        mem_we   = (cnt_q < lim_q) && (cnt_q >= ADDR_W'(flush_len_q));
        mem_addr = rd_q + cnt_q;
      end
      ST_FL_WR: begin
        mem_we   = 1'b1;
        mem_addr = rd_q + cnt_q;
        mem_wd   = v_q;
      end
      ST_PW_WR: begin
        mem_we   = 1'b1;
        mem_addr = pre_base_q + ADDR_W'(pos_q);
        mem_wd   = v_q;
      end
      ST_RING_WR: begin
        mem_we   = (applied_q != '0);
        mem_addr = wr_q;
        mem_wd   = x_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_addr] <= mem_wd;
    end
    mem_rd_q <= ring_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CAP_DATA) begin
      keep_q[cnt_q[KEEP_W-1:0]] <= mem_rd_q;
    end
    keep_rd_q <= keep_q[pos_q[KEEP_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ret_q       <= ST_IDLE;
      fmode_q     <= MODE_NONE;
      cmd_q       <= '0;
      cnt_q       <= '0;
      lim_q       <= '0;
      gap_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      applied_q   <= '0;
      pre_base_q  <= '0;
      pos_q       <= '0;
      blen_q      <= '0;
      flen_q      <= '0;
      pre_cnt_q   <= '0;
      pre_fade_q  <= '0;
      pre_old_q   <= '0;
      flush_len_q <= '0;
      flush_on_q  <= 1'b0;
      gnum_q      <= '0;
      gden_q      <= '0;
      ginv_q      <= 1'b0;
      g_q         <= '0;
      x_q         <= '0;
      v_q         <= '0;
      y_q         <= '0;
      prod_q      <= '0;
      prod2_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output register empties when taken, unless a new sample is loaded.
      if (out_o.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + ADDR_W'(1);
          if (cnt_q == ADDR_W'(RING_DEPTH - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            x_q     <= cmd_i.sample;
            state_q <= cmd_i.start ? ST_BEGIN : ST_ITEM;
          end
        end
        ST_BEGIN: begin
          blen_q     <= cmd_q.len;
          pos_q      <= '0;
          fmode_q    <= MODE_NONE;
          flen_q     <= '0;
          pre_cnt_q  <= '0;
          flush_on_q <= 1'b0;
          cnt_q      <= '0;
          if (p == '0 && d == '0) begin
            state_q <= ST_ITEM;
          end else if (p > d) begin
            pre_base_q <= wr_q;
            pre_cnt_q  <= FADE_W'(add_n);
            pre_fade_q <= FADE_W'(lout_n);
            pre_old_q  <= FADE_W'(d);
            lim_q      <= add_n;
            gap_q      <= p - d - add_n;
            flen_q     <= FADE_W'((nlen < FADE_A) ? nlen : FADE_A);
            fmode_q    <= MODE_INC;
            state_q    <= ST_PRE;
          end else if (p < d) begin
            lim_q   <= xn;
            flen_q  <= FADE_W'(xn);
            fmode_q <= MODE_DEC;
            state_q <= ST_CAP_RD;
          end else begin
            state_q <= ST_APPLY;
          end
        end
        // Increase: pre-write slots, fade out the stored tail, zero the gap.
        ST_PRE: begin
          if (cnt_q < lim_q) begin
            cnt_q <= cnt_q + ADDR_W'(1);
          end else begin
            wr_q    <= wr_q + lim_q;
            cnt_q   <= '0;
            lim_q   <= ADDR_W'(pre_fade_q);
            state_q <= ST_FO_RD;
          end
        end
        ST_FO_RD: begin
          if (cnt_q < lim_q) begin
            state_q <= ST_FO_DATA;
          end else begin
            cnt_q   <= '0;
            lim_q   <= gap_q;
            state_q <= ST_GAP;
          end
        end
        ST_FO_DATA: begin
          v_q     <= mem_rd_q;
          gnum_q  <= FADE_W'(cnt_q);
          gden_q  <= pre_fade_q;
          ginv_q  <= 1'b0;
          ret_q   <= ST_FO_WR;
          state_q <= ST_M_DIV;
        end
        ST_FO_WR: begin
          cnt_q   <= cnt_q + ADDR_W'(1);
          state_q <= ST_FO_RD;
        end
        ST_GAP: begin
          if (cnt_q < lim_q) begin
            cnt_q <= cnt_q + ADDR_W'(1);
          end else begin
            wr_q    <= wr_q + lim_q;
            state_q <= ST_APPLY;
          end
        end
        // Decrease: keep the old samples for the crossfade, then jump back.
        ST_CAP_RD: begin
          if (cnt_q < lim_q) begin
            state_q <= ST_CAP_DATA;
          end else begin
            rd_q    <= wr_q - p;
            state_q <= ST_APPLY;
          end
        end
        ST_CAP_DATA: begin
          cnt_q   <= cnt_q + ADDR_W'(1);
          state_q <= ST_CAP_RD;
        end
        ST_APPLY: begin
          applied_q <= p;
          cnt_q     <= '0;
          if (cmd_q.flush) begin
            lim_q       <= p;
            flush_len_q <= FADE_W'((p < FADE_A) ? p : FADE_A);
            flush_on_q  <= 1'b1;
            state_q     <= ST_FL;
          end else begin
            state_q <= ST_ITEM;
          end
        end
        ST_FL: begin
          if (cnt_q >= lim_q) begin
            state_q <= ST_ITEM;
          end else if (cnt_q < ADDR_W'(flush_len_q)) begin
            state_q <= ST_FL_DATA;
          end else begin
            cnt_q <= cnt_q + ADDR_W'(1);
          end
        end
        ST_FL_DATA: begin
          v_q     <= mem_rd_q;
          gnum_q  <= FADE_W'(cnt_q);
          gden_q  <= flush_len_q;
          ginv_q  <= 1'b1;
          ret_q   <= ST_FL_WR;
          state_q <= ST_M_DIV;
        end
        ST_FL_WR: begin
          cnt_q   <= cnt_q + ADDR_W'(1);
          state_q <= ST_FL;
        end
        // Per-sample work.
        ST_ITEM: begin
          if (pos_q >= blen_q) begin
            state_q <= ST_RING_WR;
          end else if (fmode_q == MODE_INC) begin
            state_q <= (pos_q < pre_cnt_q) ? ST_PW : ST_FI_CHK;
          end else if (fmode_q == MODE_DEC && pos_q < flen_q) begin
            gnum_q  <= FADE_W'(pos_q);
            gden_q  <= flen_q;
            state_q <= ST_XF_DIV;
          end else begin
            state_q <= ST_RING_WR;
          end
        end
        ST_PW: begin
          v_q <= x_q;
          if (pre_s < ADDR_W'(pre_fade_q)) begin
            gnum_q  <= FADE_W'(pre_s);
            gden_q  <= pre_fade_q;
            ginv_q  <= 1'b0;
            ret_q   <= ST_PW_FL;
            state_q <= ST_M_DIV;
          end else begin
            state_q <= ST_PW_FL;
          end
        end
        ST_PW_FL: begin
          if (!flush_on_q) begin
            state_q <= ST_PW_WR;
          end else if (sf < (FADE_W + 1)'(flush_len_q)) begin
            gnum_q  <= FADE_W'(sf);
            gden_q  <= flush_len_q;
            ginv_q  <= 1'b1;
            ret_q   <= ST_PW_WR;
            state_q <= ST_M_DIV;
          end else begin
            v_q     <= '0;
            state_q <= ST_PW_WR;
          end
        end
        ST_PW_WR: begin
          state_q <= ST_FI_CHK;
        end
        ST_FI_CHK: begin
          if (pos_q < flen_q) begin
            v_q     <= x_q;
            gnum_q  <= FADE_W'(pos_q);
            gden_q  <= flen_q;
            ginv_q  <= 1'b0;
            ret_q   <= ST_FI_DONE;
            state_q <= ST_M_DIV;
          end else begin
            state_q <= ST_RING_WR;
          end
        end
        ST_FI_DONE: begin
          x_q     <= v_q;
          state_q <= ST_RING_WR;
        end
        ST_XF_DIV: begin
          state_q <= ST_XF_WAIT;
        end
        ST_XF_WAIT: begin
          if (div_done) begin
            g_q     <= div_quot;
            state_q <= ST_XF_P1;
          end
        end
        ST_XF_P1: begin
          prod_q  <= x_q * $signed({1'b0, g_q});
          state_q <= ST_XF_P2;
        end
        ST_XF_P2: begin
          prod2_q <= keep_rd_q * $signed({1'b0, GAIN_W'(UNITY) - g_q});
          state_q <= ST_XF_SUM;
        end
        ST_XF_SUM: begin
          x_q     <= rnd16(prod_q + prod2_q);
          state_q <= ST_RING_WR;
        end
        // The finished sample stays in x_q until the output register is free.
        ST_RING_WR: begin
          if (applied_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            wr_q    <= wr_q + ADDR_W'(1);
            state_q <= ST_RING_RD;
          end
        end
        ST_RING_RD: begin
          rd_q    <= rd_q + ADDR_W'(1);
          state_q <= ST_RING_DATA;
        end
        ST_RING_DATA: begin
          x_q     <= mem_rd_q;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            y_q         <= x_q;
            if (pos_q < POS_W'(MAX_BLOCK)) begin
              pos_q <= pos_q + POS_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        // Shared gain multiply: v = round(v * g), g = s/len or 1 - s/len.
        ST_M_DIV: begin
          state_q <= ST_M_WAIT;
        end
        ST_M_WAIT: begin
          if (div_done) begin
            g_q     <= ginv_q ? GAIN_W'(UNITY) - div_quot : div_quot;
            state_q <= ST_M_PROD;
          end
        end
        ST_M_PROD: begin
          prod_q  <= v_q * $signed({1'b0, g_q});
          state_q <= ST_M_RND;
        end
        ST_M_RND: begin
          v_q     <= rnd16(prod_q);
          state_q <= ret_q;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/latency_delay_line_with_fades_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency delay line with fades
// One-channel variable delay on a ring memory with click-free delay changes.
// ----------------------------------------------------------------------------
// Each request writes its sample into the ring and returns the sample one
// applied delay older; a delay of zero passes samples straight through. The
// target_delay register is sampled at the next request that marks a block
// start. After reset the ring is cleared, during which no request is
// accepted (the configuration register can still be written). Requests
// inside a fade take longer for each gain, since every gain goes through
// one shared divider that produces one quotient bit per cycle; a pre-written
// sample during a flush takes longest. A block start that changes the delay
// or flushes walks the single-port ring slot by slot, zeroing or fading
// each slot, so a large increase or a flush can stall requests while it runs.
// A four-entry command queue decouples acceptance from the ring engine, and
// an output register holds a finished sample until it is taken.
module latency_delay_line_with_fades_top import ldf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ldf_in_if.sink             in_i,
  ldf_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [DELAY_W-1:0] cfg_wdata_i
);

  // Front end to queue.
  logic push;
  cmd_t push_cmd;
  logic fifo_ready;

  // Queue to ring engine.
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // The ring engine blocks new requests while it clears the ring.
  logic clearing;

  ldf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .clearing_i   (clearing),
    .fifo_ready_i (fifo_ready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ldf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (fifo_ready),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd)
  );

  ldf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule

[design/ldf_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line port checker
// Watches the top-level channels for ordering and stall behavior.
// ----------------------------------------------------------------------------
module ldf_chk import ldf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [SAMPLE_W-1:0] out_data_i
);

  // Queue, engine and output register together hold this many requests.
  localparam int MAX_OPEN = FIFO_DEPTH + 2;
  localparam int OW = $clog2(MAX_OPEN + 2);

  logic [OW-1:0] open_q;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc) begin
      open_q <= open_q + OW'(1);
    end else if (out_acc && !in_acc) begin
      open_q <= open_q - OW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != '0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= OW'(MAX_OPEN))
    else $error("too many requests in flight");

  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("request accepted before the ring was cleared");

endmodule

bind latency_delay_line_with_fades_top ldf_chk u_ldf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.delayed_sample)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line with fades testbench
// Drives sample requests through the latency delay line, changes the target
// delay between phases and checks every delayed sample against a cycle-free
// predictor of the ring, the fades, the pre-writes and the flushes.
// ----------------------------------------------------------------------------
module tb;
  import ldf_pkg::*;

  // Fade state of the predictor: no fade, fade-in after an increase, or a
  // crossfade with old ring data after a decrease.
  typedef enum int {FADE_NONE, FADE_RISE, FADE_CROSS} fade_e;

  // One accepted request as seen at the input channel.
  typedef struct {
    int          sample;
    bit          start;
    int unsigned len;
    bit          flush;
  } request_t;

  // The scoreboard holds its own copy of the ring and the fade bookkeeping.
  // note_request() advances the predicted block by one request and queues the
  // delayed sample it must produce; check_result() compares what came out.
  class ldf_scoreboard;
    int          ring [RING_DEPTH];
    int unsigned rd_ofs, wr_ofs, applied, blk_pos, fade_count, blk_len;
    int unsigned pre_base, pre_count, pre_fade, pre_old, flush_len;
    int unsigned target;
    fade_e       mode;
    bit          flush_on;
    int          keep [FADE_SAMPLES];
    int          expected_q [$];
    int unsigned mismatches, results, requests;

    function new();
      foreach (ring[i]) ring[i] = 0;
      foreach (keep[i]) keep[i] = 0;
      rd_ofs = 0; wr_ofs = 0; applied = 0; blk_pos = 0; fade_count = 0;
      blk_len = 0; pre_base = 0; pre_count = 0; pre_fade = 0; pre_old = 0;
      flush_len = 0; target = 0; mode = FADE_NONE; flush_on = 0;
      mismatches = 0; results = 0; requests = 0;
    endfunction

    function int unsigned gain_q16(int unsigned s, int unsigned n);
      if (n == 0) return UNITY;
      return int'((longint'(s) * UNITY + n / 2) / n);
    endfunction

    // Round to nearest after the 16-bit shift, ties toward plus infinity.
    function int round_q16(longint t);
      return int'((t + 32768) >>> GAIN_SHIFT);
    endfunction

    function int scale(int x, int unsigned g);
      return round_q16(longint'(x) * longint'(g));
    endfunction

    function int unsigned wrap(int unsigned a);
      return a & (RING_DEPTH - 1);
    endfunction

    function int unsigned min2(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
    endfunction

    function void start_block(int unsigned n, bit flush);
      int unsigned p, d, add, lout, gap, x, lf, o;
      p = (target > DELAY_LIMIT) ? DELAY_LIMIT : target;
      d = applied;
      if (n > MAX_BLOCK) n = MAX_BLOCK;
      blk_len = n;
      blk_pos = 0;
      mode = FADE_NONE;
      fade_count = 0;
      pre_count = 0;
      flush_on = 0;
      if (p == d && d == 0) return;
      if (p > d) begin
        add = 0;
        lout = FADE_SAMPLES;
        if (d < FADE_SAMPLES) begin
          add = min2(FADE_SAMPLES - d, p - d);
          lout = d + add;
        end
        pre_base = wr_ofs;
        for (int unsigned s = 0; s < add; s++) ring[wrap(pre_base + s)] = 0;
        wr_ofs = wrap(wr_ofs + add);
        for (int unsigned s = 0; s < lout; s++) begin
          o = wrap(wr_ofs - s);
          ring[o] = scale(ring[o], gain_q16(s, lout));
        end
        gap = p - d - add;
        for (int unsigned s = 0; s < gap; s++) ring[wrap(wr_ofs + s)] = 0;
        wr_ofs = wrap(wr_ofs + gap);
        pre_count = add;
        pre_fade = lout;
        pre_old = d;
        fade_count = min2(n, FADE_SAMPLES);
        mode = FADE_RISE;
      end else if (p < d) begin
        x = min2(min2(d, FADE_SAMPLES), min2(n, FADE_SAMPLES));
        for (int unsigned s = 0; s < x; s++) keep[s] = ring[wrap(rd_ofs + s)];
        rd_ofs = wrap(wr_ofs - p);
        fade_count = x;
        mode = FADE_CROSS;
      end
      applied = p;
      if (flush) begin
        lf = min2(p, FADE_SAMPLES);
        for (int unsigned s = 0; s < p; s++) begin
          o = wrap(rd_ofs + s);
          if (s < lf) ring[o] = scale(ring[o], UNITY - gain_q16(s, lf));
          else ring[o] = 0;
        end
        flush_on = 1;
        flush_len = lf;
      end
    endfunction

    function void note_request(request_t r);
      int          x, v, y;
      int unsigned s, g;
      x = r.sample;
      requests++;
      if (r.start) start_block(r.len, r.flush);
      if (blk_pos < blk_len) begin
        if (mode == FADE_RISE) begin
          if (blk_pos < pre_count) begin
            v = x;
            s = pre_count - blk_pos;
            if (s < pre_fade) v = scale(v, gain_q16(s, pre_fade));
            if (flush_on) begin
              s = pre_old + blk_pos;
              if (s < flush_len) v = scale(v, UNITY - gain_q16(s, flush_len));
              else v = 0;
            end
            ring[wrap(pre_base + blk_pos)] = v;
          end
          if (blk_pos < fade_count) x = scale(x, gain_q16(blk_pos, fade_count));
        end else if (mode == FADE_CROSS && blk_pos < fade_count && blk_pos < FADE_SAMPLES) begin
          g = gain_q16(blk_pos, fade_count);
          x = round_q16(longint'(x) * longint'(g) +
                        longint'(keep[blk_pos]) * longint'(UNITY - g));
        end
      end
      if (applied == 0) begin
        y = x;
      end else begin
        ring[wr_ofs] = x;
        wr_ofs = wrap(wr_ofs + 1);
        y = ring[rd_ofs];
        rd_ofs = wrap(rd_ofs + 1);
      end
      if (blk_pos < MAX_BLOCK) blk_pos++;
      expected_q.insert(expected_q.size(), y);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected delayed_sample %0d with nothing pending", got);
        return;
      end
      want = SAMPLE_W'(expected_q.pop_front());
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: delayed_sample expected %0d, got %0d", results, want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [DELAY_W-1:0] cfg_wdata_i;

  ldf_in_if  req_if ();
  ldf_out_if res_if ();

  latency_delay_line_with_fades_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ldf_scoreboard sb = new();

  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned ITEM_GOAL   = 550;

  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned phase_count;
  int unsigned flush_count;
  int unsigned sent_count;
  int unsigned stall_mode;

  // The clock starts with every input of the block at a known value, so the
  // block never sees an undriven request or configuration write.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.sample_in = '0;
    req_if.block_start = 1'b0;
    req_if.block_length = '0;
    req_if.flush_request = 1'b0;
    res_if.ready = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog. The slowest legal run is dominated by the clearing pass after
  // reset and by the ring walks of large delay increases; the limit is many
  // times that.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count, sb.pending());
      $display("tb: FAIL");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own: it switches periodically
  // between always ready, random ready, mostly stalled and a slow square wave.
  always @(posedge clk_i) begin
    if (cycle_count % 50 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= 1'($urandom_range(0, 1));
      2: res_if.ready <= ($urandom_range(0, 3) == 0);
      default: res_if.ready <= cycle_count[2];
    endcase
  end

  // Both channels are observed at the clock edge; the values read here are the
  // ones that held just before the edge, which is when the handshake counts.
  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        r.sample = int'(req_if.sample_in);
        r.start = req_if.block_start;
        r.len = req_if.block_length;
        r.flush = req_if.flush_request;
        sb.note_request(r);
      end
      if (res_if.valid && res_if.ready) sb.check_result(res_if.delayed_sample);
    end
  end

  // Waits until every expected sample has come back, then lets the block
  // settle before the register changes; a new delay must never race a
  // request that is still inside the ring engine.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic program_delay(int unsigned value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= DELAY_W'(value);
    sb.target = value & 16'hFFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phase_count++;
  endtask

  // Sends one request. The sender works in bursts: when a burst runs out,
  // valid drops for a random gap before the next burst begins.
  task automatic send_request(int sample, bit start, int unsigned len, bit flush);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.sample_in <= SAMPLE_W'(sample);
    req_if.block_start <= start;
    req_if.block_length <= LEN_W'(len);
    req_if.flush_request <= flush;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_count++;
    if (start && flush) flush_count++;
  endtask

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      default: return int'($urandom() << 8) >>> 8;
    endcase
  endfunction

  // One block: a block start followed by its samples. Sometimes the block is
  // cut short by the next block start, sometimes it runs past its length so
  // plain delay requests follow. Requests without a block start carry random
  // length and flush bits, which the block must ignore. Near the end of the
  // run the block is trimmed so the total stays close to the goal.
  task automatic send_block();
    int unsigned len, count;
    bit flush;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = $urandom_range(129, 400);
      default: len = $urandom_range(1, 140);
    endcase
    flush = ($urandom_range(0, 4) == 0);
    count = (len == 0) ? $urandom_range(1, 8) : len;
    case ($urandom_range(0, 5))
      0: count = count + $urandom_range(1, 20);
      1: count = $urandom_range(1, count);
      default: ;
    endcase
    if (sent_count + count > ITEM_GOAL)
      count = (sent_count < ITEM_GOAL) ? ITEM_GOAL - sent_count : 1;
    send_request(pick_sample(), 1'b1, len, flush);
    for (int unsigned i = 1; i < count; i++)
      send_request(pick_sample(), 1'b0, $urandom_range(0, 16383),
                   1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned pick, blocks;
    cycle_count = 0;
    burst_left = 0;
    phase_count = 0;
    flush_count = 0;
    sent_count = 0;
    stall_mode = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. At zero delay with nothing to change, a flush does
    // nothing and samples pass straight through, extremes included.
    send_request(8388607, 1'b1, 4, 1'b1);
    send_request(-8388608, 1'b0, 16383, 1'b1);
    send_request(1, 1'b0, 0, 1'b0);
    send_request(-1, 1'b0, 8191, 1'b0);

    // A register value above the ring limit saturates; the longest block
    // length saturates to the largest block.
    program_delay(65535);
    send_request(-8388608, 1'b1, 16383, 1'b0);
    send_request(8388607, 1'b0, 5, 1'b1);
    send_request(123456, 1'b0, 9, 1'b0);

    // A decrease with a zero-length block: no crossfade at all.
    program_delay(3);
    send_request(8388607, 1'b1, 0, 1'b0);
    send_request(-8388608, 1'b0, 1, 1'b0);

    // An increase from a short delay pre-writes inputs; the block is cut short by
    // the next block start before the pre-write count, and a flush clears the stored data.
    program_delay(200);
    send_request(8388607, 1'b1, 8192, 1'b1);
    send_request(-8388608, 1'b0, 0, 1'b0);
    send_request(4000000, 1'b0, 0, 1'b0);
    send_request(-4000000, 1'b0, 0, 1'b0);
    send_request(-8388608, 1'b1, 2, 1'b0);
    send_request(8388607, 1'b0, 0, 1'b0);
    send_request(77, 1'b0, 0, 1'b0);

    // Back to zero delay with a flush: a decrease that then passes through.
    program_delay(0);
    send_request(-8388608, 1'b1, 2, 1'b1);
    send_request(8388607, 1'b0, 3, 1'b0);
    send_request(-5, 1'b0, 12000, 1'b1);

    // Random part: phases of one to three blocks, each phase at a new delay.
    // Mostly short delays so fades and pre-writes happen often; a large delay
    // now and then for the long ring walk.
    while (sent_count < ITEM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) program_delay(0);
      else if (pick == 3) program_delay($urandom_range(50000, 65535));
      else if (pick < 10) program_delay($urandom_range(1, 127));
      else program_delay($urandom_range(128, 1500));
      blocks = $urandom_range(1, 3);
      repeat (blocks) send_block();
    end

    // Hold off until everything is out, then allow the tail latency.
    drain();
    repeat (200) @(posedge clk_i);
    if (sb.pending() > 0) begin
      sb.mismatches++;
      $display("%0d expected samples never arrived", sb.pending());
    end

    $display("covered %0d requests and %0d results over %0d delay settings, %0d flushes",
             sb.requests, sb.results, phase_count, flush_count);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[latency_delay_line_with_fades_top.f]
design/ldf_pkg.sv
design/ldf_if.sv
design/ldf_div.sv
design/ldf_fifo.sv
design/ldf_front.sv
design/ldf_back.sv
design/latency_delay_line_with_fades_top.sv
design/ldf_chk.sv
tb/tb.sv
